// ===== src/bfa_pkg.sv =====
// Package for the bitmap frame allocator: sizes, codes and payload types.
// No dependencies.
package bfa_pkg;
   localparam int NUM_FRAMES = 1024;
   localparam int ADDR_WIDTH = 32;
   localparam int FRAME_SHIFT = 12;
   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_RESERVE = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_BUSY    = 2'd2,
      ST_NOMEM   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] base_addr;
      logic [31:0] limit_addr;
      logic [15:0] page_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] run_addr;
      logic [10:0] free_left;
   } rsp_type;
endpackage

// ===== src/bfa_if.sv =====
// Valid/ready channels for request and response words.
// Depends on bfa_pkg.
interface bfa_req_if import bfa_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/bitmap_frame_allocator_unit.sv =====
// Bitmap frame allocator: one bit per 4 KiB frame, first-fit run search,
// free and reserve with range checks. Depends on bfa_pkg, bfa_if, bfa_ram.
//
// One request word at a time. The frame map lives in a single-port RAM
// read and written one frame a cycle by a sequencer around one shared
// index counter and compare. Allocate scans frames and then marks the run,
// where a search without a fit scans the whole window and marks nothing;
// free and reserve check the run and then mark it, stopping early at an
// offending frame; a request rejected by its range checks goes straight to
// its response. A response waiting on rsp ready holds back only the next
// response, not the next request. After reset and after each frame_count
// write, a clearing pass over all NUM_FRAMES frames runs, during which no
// request is accepted.
module bitmap_frame_allocator_unit
   import bfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [10:0]       csr_wr_data,
   bfa_req_if.sink           req,
   bfa_rsp_if.source         rsp
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_MARK, S_DONE
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   fcount_ff, free_ff;
   logic [CNT_W:0]     idx_ff;      // current frame
   logic [CNT_W:0]     hi_ff;       // exclusive end
   logic [CNT_W:0]     start_ff;
   logic [16:0]        run_ff;
   logic [15:0]        pages_ff;
   logic [1:0]         func_ff;
   logic               rd_pend_ff;
   logic               mark_val_ff;
   logic [1:0]         status_ff;
   logic [31:0]        addr_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               ram_we, ram_wd, ram_rd;
   logic [IDX_W-1:0]   ram_addr;

   bfa_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   // request decode
   logic [ADDR_WIDTH-1:0] b, l;
   logic [ADDR_WIDTH:0]   lo_w;
   logic [ADDR_WIDTH:0]   hi_w, cnt_x;
   logic [ADDR_WIDTH:0]   f_w, end_w;
   assign b = req.data.base_addr[ADDR_WIDTH-1:0];
   assign l = req.data.limit_addr[ADDR_WIDTH-1:0];
   assign cnt_x = (ADDR_WIDTH+1)'(fcount_ff);
   always_comb begin
      lo_w = (b != '0) ? (({1'b0, b} + (ADDR_WIDTH+1)'(4095)) >> FRAME_SHIFT) : '0;
      hi_w = (l != '0) ? (ADDR_WIDTH+1)'(l >> FRAME_SHIFT) : cnt_x;
      if (hi_w > cnt_x) hi_w = cnt_x;
      f_w   = (ADDR_WIDTH+1)'(b >> FRAME_SHIFT);
      end_w = f_w + (ADDR_WIDTH+1)'(req.data.page_count);
   end

   assign req.ready = (state_ff == S_IDLE) && !csr_wr_en;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   always_comb begin
      ram_we   = 1'b0;
      ram_wd   = mark_val_ff;
      ram_addr = idx_ff[IDX_W-1:0];
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1;
         ram_wd = 1'b0;
      end else if (state_ff == S_MARK) begin
         ram_we = 1'b1;
      end
   end

   // read data for frame idx_ff-1 arrives when rd_pend_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fcount_ff    <= CNT_W'(NUM_FRAMES);
         free_ff      <= CNT_W'(NUM_FRAMES);
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            fcount_ff <= (csr_wr_data > 11'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES)
                                                         : CNT_W'(csr_wr_data);
            free_ff   <= (csr_wr_data > 11'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES)
                                                         : CNT_W'(csr_wr_data);
            idx_ff    <= '0;
            state_ff  <= S_CLEAR;
         end else begin
            unique case (state_ff)
               S_CLEAR: begin
                  idx_ff <= idx_ff + 1'b1;
                  if (idx_ff == (CNT_W+1)'(NUM_FRAMES - 1)) state_ff <= S_IDLE;
               end
               S_IDLE: begin
                  rd_pend_ff <= 1'b0;
                  if (req.valid && req.ready) begin
                     func_ff   <= req.data.func;
                     pages_ff  <= req.data.page_count;
                     run_ff    <= '0;
                     addr_ff   <= '0;
                     status_ff <= ST_INVALID;
                     state_ff  <= S_DONE;
                     if (req.data.page_count != 0) begin
                        if (req.data.func == FUNC_ALLOC) begin
                           if (lo_w < hi_w) begin
                              idx_ff    <= lo_w[CNT_W:0];
                              start_ff  <= lo_w[CNT_W:0];
                              hi_ff     <= hi_w[CNT_W:0];
                              status_ff <= ST_NOMEM;
                              state_ff  <= S_SCAN;
                           end
                        end else if (req.data.func == FUNC_FREE ||
                                     req.data.func == FUNC_RESERVE) begin
                           if (b[FRAME_SHIFT-1:0] == '0 && f_w < cnt_x &&
                               end_w <= cnt_x) begin
                              idx_ff    <= f_w[CNT_W:0];
                              start_ff  <= f_w[CNT_W:0];
                              hi_ff     <= end_w[CNT_W:0];
                              status_ff <= (req.data.func == FUNC_FREE)
                                           ? ST_INVALID : ST_BUSY;
                              state_ff  <= S_CHECK;
                           end
                        end
                     end
                  end
               end
               S_SCAN, S_CHECK: begin
                  // issue read of idx_ff, consume data of previous
                  logic hit, done_run;
                  hit = 1'b0; done_run = 1'b0;
                  if (rd_pend_ff) begin
                     if (state_ff == S_SCAN) begin
                        if (ram_rd) begin
                           run_ff   <= '0;
                           start_ff <= idx_ff;
                        end else begin
                           run_ff <= run_ff + 1'b1;
                           if (run_ff + 1'b1 == {1'b0, pages_ff}) done_run = 1'b1;
                        end
                     end else begin
                        hit = (func_ff == FUNC_FREE) ? !ram_rd : ram_rd;
                        run_ff <= run_ff + 1'b1;
                        if (run_ff + 1'b1 == {1'b0, pages_ff}) done_run = 1'b1;
                     end
                  end
                  if (hit) begin
                     state_ff   <= S_DONE;
                     rd_pend_ff <= 1'b0;
                  end else if (done_run) begin
                     idx_ff      <= start_ff;
                     mark_val_ff <= (func_ff != FUNC_FREE);
                     run_ff      <= '0;
                     rd_pend_ff  <= 1'b0;
                     status_ff   <= ST_OK;
                     if (func_ff == FUNC_ALLOC)
                        addr_ff <= 32'(start_ff) << FRAME_SHIFT;
                     state_ff <= S_MARK;
                  end else if (idx_ff >= hi_ff) begin
                     state_ff   <= S_DONE;
                     rd_pend_ff <= 1'b0;
                  end else begin
                     idx_ff     <= idx_ff + 1'b1;
                     rd_pend_ff <= 1'b1;
                  end
               end
               S_MARK: begin
                  idx_ff <= idx_ff + 1'b1;
                  run_ff <= run_ff + 1'b1;
                  if (run_ff + 1'b1 == {1'b0, pages_ff}) begin
                     if (func_ff == FUNC_FREE) free_ff <= free_ff + CNT_W'(pages_ff);
                     else free_ff <= free_ff - CNT_W'(pages_ff);
                     state_ff <= S_DONE;
                  end
               end
               S_DONE: begin
                  if (!rsp_valid_ff || rsp.ready) begin
                     rsp_ff.status    <= status_ff;
                     rsp_ff.run_addr  <= addr_ff;
                     rsp_ff.free_left <= 11'(free_ff);
                     rsp_valid_ff     <= 1'b1;
                     state_ff         <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end
endmodule

// ===== src/bfa_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module bfa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
